// ----- rtl/core/dfs_pkg.sv -----
// Shared types, constants and control bundles for the depth-first topological sort block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package dfs_pkg;

  // graph size and derived widths
  localparam int MaxVertices = 64;
  localparam int VtxW        = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CntW        = $clog2(MaxVertices + 1);

  // fixed field widths
  localparam int ModeW   = 2;
  localparam int FieldW  = 7;
  localparam int CfgW    = 7;
  localparam int StatusW = 2;

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [ModeW-1:0] {
    MODE_EDGE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_CYCLE = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_WHITE = 2'd0,
    MARK_GRAY  = 2'd1,
    MARK_BLACK = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_WR,
    S_RESULT,
    S_INIT,
    S_ROOT,
    S_ROOT_CHK,
    S_ROW,
    S_SCAN,
    S_SUCC,
    S_POP,
    S_EMIT_RD,
    S_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    edge_rd;
    logic    edge_wr;
    logic    adj_clr;
    logic    init_start;
    logic    init_mark;
    logic    root_start;
    logic    root_rd;
    logic    root_next;
    logic    root_enter;
    logic    row_load;
    logic    scan_next;
    logic    finish;
    logic    pop_rd;
    logic    pop_load;
    logic    push;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  edge_bad;
    logic  n_zero;
    logic  init_done;
    logic  root_end;
    logic  scan_end;
    logic  row_bit;
    mark_e mark_rd;
    logic  depth_zero;
    logic  fill_one;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/core/dfs_if.sv -----
// Request and result channel interfaces with valid/ready handshake.
// Depends on dfs_pkg for field widths.
`timescale 1ns / 1ps

interface dfs_in_if;
  import dfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [FieldW-1:0] from_vertex;
  logic [FieldW-1:0] to_vertex;
  modport source (output valid, mode, from_vertex, to_vertex, input ready);
  modport sink   (input valid, mode, from_vertex, to_vertex, output ready);
endinterface

interface dfs_out_if;
  import dfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [FieldW-1:0]  vertex;
  logic [StatusW-1:0] status;
  logic               last;
  modport source (output valid, vertex, status, last, input ready);
  modport sink   (input valid, vertex, status, last, output ready);
endinterface

// ----- rtl/core/dfs_ctrl.sv -----
// Sequencer for edge loads, clears and the depth-first walk.
// Depends on dfs_pkg; drives commands into dfs_dpath and reads its status.
`timescale 1ns / 1ps

module dfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dfs_pkg::sts_t sts_i,
  output dfs_pkg::cmd_t cmd_o
);
  import dfs_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  // state and pending result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.mode)
          MODE_EDGE: begin
            if (sts_i.edge_bad) begin
              res_d   = ST_BAD;
              state_d = S_RESULT;
            end else begin
              cmd_o.edge_rd = 1'b1;
              state_d       = S_EDGE_WR;
            end
          end
          MODE_RUN: begin
            if (sts_i.n_zero) begin
              res_d   = ST_EMPTY;
              state_d = S_RESULT;
            end else begin
              cmd_o.init_start = 1'b1;
              state_d          = S_INIT;
            end
          end
          MODE_CLEAR: begin
            cmd_o.adj_clr = 1'b1;
            state_d       = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_RESULT: begin
        cmd_o.out_status = res_q;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_INIT: begin
        cmd_o.init_mark = 1'b1;
        if (sts_i.init_done) begin
          cmd_o.root_start = 1'b1;
          state_d          = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root_rd = 1'b1;
        if (sts_i.root_end) state_d = S_EMIT_RD;
        else                state_d = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (sts_i.mark_rd != MARK_WHITE) begin
          cmd_o.root_next = 1'b1;
          state_d         = S_ROOT;
        end else begin
          cmd_o.root_enter = 1'b1;
          state_d          = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_load = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.finish = 1'b1;
          if (sts_i.depth_zero) begin
            cmd_o.root_next = 1'b1;
            state_d         = S_ROOT;
          end else begin
            cmd_o.pop_rd = 1'b1;
            state_d      = S_POP;
          end
        end else if (sts_i.row_bit) begin
          state_d = S_SUCC;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_SUCC: begin
        unique case (sts_i.mark_rd)
          MARK_GRAY: begin
            res_d   = ST_CYCLE;
            state_d = S_RESULT;
          end
          MARK_WHITE: begin
            cmd_o.push = 1'b1;
            state_d    = S_ROW;
          end
          default: begin
            cmd_o.scan_next = 1'b1;
            state_d         = S_SCAN;
          end
        endcase
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_ROW;
      end
      S_EMIT_RD: state_d = S_EMIT;
      S_EMIT: begin
        cmd_o.out_status = ST_OK;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.fill_one ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/dfs_dpath.sv -----
// Datapath: adjacency matrix, marks, walk stack, finish list, counters and result register.
// Depends on dfs_pkg; sequenced by dfs_ctrl through cmd_t and reports back through sts_t.
`timescale 1ns / 1ps

module dfs_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dfs_pkg::CfgW-1:0]       cfg_data_i,
  input  logic [dfs_pkg::ModeW-1:0]      mode_i,
  input  logic [dfs_pkg::FieldW-1:0]     from_vertex_i,
  input  logic [dfs_pkg::FieldW-1:0]     to_vertex_i,
  input  dfs_pkg::cmd_t                  cmd_i,
  output dfs_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dfs_pkg::FieldW-1:0]     out_vertex_o,
  output logic [dfs_pkg::StatusW-1:0]    out_status_o,
  output logic                           out_last_o
);
  import dfs_pkg::*;

  // configuration and latched request
  logic [CfgW-1:0]   vcount_q;
  mode_e             mode_q;
  logic [FieldW-1:0] from_q, to_q;
  cnt_t              n;
  logic [FieldW-1:0] n_w;
  vtx_t              from_idx, to_idx;

  // memories
  logic [MaxVertices-1:0] adj_mem [MaxVertices];
  logic [MaxVertices-1:0] adj_vld_q;
  logic [MaxVertices-1:0] adj_rd_q, row_q;
  logic                   adj_rd_vld_q;
  mark_e                  mark_mem [MaxVertices];
  mark_e                  mark_rd_q;
  vtx_t                   fin_mem [MaxVertices];
  vtx_t                   fin_rd_q;
  vtx_t                   stk_v_mem [MaxVertices];
  cnt_t                   stk_i_mem [MaxVertices];
  vtx_t                   stk_v_rd_q;
  cnt_t                   stk_i_rd_q;

  // walk counters
  cnt_t k_q, root_q, cur_i_q, depth_q, fill_q;
  vtx_t cur_v_q;

  // result register
  logic              out_valid_q;
  logic [FieldW-1:0] out_vertex_q;
  status_e           out_status_q;
  logic              out_last_q;

  // port muxes
  vtx_t  adj_addr, mark_waddr, mark_raddr;
  mark_e mark_wdata;
  logic  mark_we;

  assign n        = (vcount_q > CfgW'(MaxVertices)) ? cnt_t'(MaxVertices) : cnt_t'(vcount_q);
  assign n_w      = FieldW'(n);
  assign from_idx = vtx_t'(from_q - FieldW'(1));
  assign to_idx   = vtx_t'(to_q - FieldW'(1));

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       vcount_q <= '0;
    else if (cfg_we_i) vcount_q <= cfg_data_i;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_e'(mode_i);
      from_q <= from_vertex_i;
      to_q   <= to_vertex_i;
    end
  end

  // adjacency read address
  always_comb begin
    adj_addr = from_idx;
    if (cmd_i.root_enter)    adj_addr = root_q[VtxW-1:0];
    else if (cmd_i.push)     adj_addr = cur_i_q[VtxW-1:0];
    else if (cmd_i.pop_load) adj_addr = stk_v_rd_q;
  end

  // adjacency row memory
  always_ff @(posedge clk_i) begin
    adj_rd_q <= adj_mem[adj_addr];
    if (cmd_i.edge_wr) begin
      adj_mem[from_idx] <= (adj_rd_vld_q ? adj_rd_q : '0)
                         | ({{(MaxVertices-1){1'b0}}, 1'b1} << to_idx);
    end
  end

  // per-row valid bits, cleared by reset and by the clear request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q    <= '0;
      adj_rd_vld_q <= 1'b0;
    end else begin
      adj_rd_vld_q <= adj_vld_q[adj_addr];
      if (cmd_i.adj_clr)      adj_vld_q           <= '0;
      else if (cmd_i.edge_wr) adj_vld_q[from_idx] <= 1'b1;
    end
  end

  // current row under scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_load) row_q <= adj_rd_vld_q ? adj_rd_q : '0;
  end

  // mark write port
  always_comb begin
    mark_we    = 1'b1;
    mark_waddr = k_q[VtxW-1:0];
    mark_wdata = MARK_WHITE;
    if (cmd_i.root_enter) begin
      mark_waddr = root_q[VtxW-1:0];
      mark_wdata = MARK_GRAY;
    end else if (cmd_i.push) begin
      mark_waddr = cur_i_q[VtxW-1:0];
      mark_wdata = MARK_GRAY;
    end else if (cmd_i.finish) begin
      mark_waddr = cur_v_q;
      mark_wdata = MARK_BLACK;
    end else if (!cmd_i.init_mark) begin
      mark_we = 1'b0;
    end
  end

  assign mark_raddr = cmd_i.root_rd ? root_q[VtxW-1:0] : cur_i_q[VtxW-1:0];

  // mark memory
  always_ff @(posedge clk_i) begin
    mark_rd_q <= mark_mem[mark_raddr];
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
  end

  // finish list memory, read at the newest entry
  always_ff @(posedge clk_i) begin
    fin_rd_q <= fin_mem[vtx_t'(fill_q - cnt_t'(1))];
    if (cmd_i.finish) fin_mem[fill_q[VtxW-1:0]] <= cur_v_q;
  end

  // walk stack memory, read at the top saved frame
  always_ff @(posedge clk_i) begin
    stk_v_rd_q <= stk_v_mem[vtx_t'(depth_q - cnt_t'(1))];
    stk_i_rd_q <= stk_i_mem[vtx_t'(depth_q - cnt_t'(1))];
    if (cmd_i.push) begin
      stk_v_mem[depth_q[VtxW-1:0]] <= cur_v_q;
      stk_i_mem[depth_q[VtxW-1:0]] <= cur_i_q + cnt_t'(1);
    end
  end

  // walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      root_q  <= '0;
      cur_v_q <= '0;
      cur_i_q <= '0;
      depth_q <= '0;
      fill_q  <= '0;
    end else begin
      if (cmd_i.init_start)     k_q <= '0;
      else if (cmd_i.init_mark) k_q <= k_q + cnt_t'(1);

      if (cmd_i.root_start)     root_q <= '0;
      else if (cmd_i.root_next) root_q <= root_q + cnt_t'(1);

      if (cmd_i.root_enter) begin
        cur_v_q <= root_q[VtxW-1:0];
        cur_i_q <= '0;
        depth_q <= '0;
      end else if (cmd_i.push) begin
        cur_v_q <= cur_i_q[VtxW-1:0];
        cur_i_q <= '0;
        depth_q <= depth_q + cnt_t'(1);
      end else if (cmd_i.pop_load) begin
        cur_v_q <= stk_v_rd_q;
        cur_i_q <= stk_i_rd_q;
      end else if (cmd_i.scan_next) begin
        cur_i_q <= cur_i_q + cnt_t'(1);
      end
      if (cmd_i.pop_rd) depth_q <= depth_q - cnt_t'(1);

      if (cmd_i.root_start)  fill_q <= '0;
      else if (cmd_i.finish) fill_q <= fill_q + cnt_t'(1);
      else if (cmd_i.out_load && cmd_i.out_status == ST_OK) fill_q <= fill_q - cnt_t'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i)    out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      if (cmd_i.out_status == ST_OK) begin
        out_vertex_q <= FieldW'(fin_rd_q) + FieldW'(1);
        out_last_q   <= (fill_q == cnt_t'(1));
      end else begin
        out_vertex_q <= '0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  // status back to the controller
  assign sts_o.mode       = mode_q;
  assign sts_o.edge_bad   = (from_q == '0) || (to_q == '0) || (from_q > n_w) || (to_q > n_w);
  assign sts_o.n_zero     = (n == '0);
  assign sts_o.init_done  = (k_q == n - cnt_t'(1));
  assign sts_o.root_end   = (root_q == n);
  assign sts_o.scan_end   = (cur_i_q == n);
  assign sts_o.row_bit    = row_q[cur_i_q[VtxW-1:0]];
  assign sts_o.mark_rd    = mark_rd_q;
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.fill_one   = (fill_q == cnt_t'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/core/dfs_topological_sort.sv -----
// Top level of the depth-first topological sort block.
// Depends on dfs_pkg, dfs_if, dfs_ctrl and dfs_dpath.
//
// Usage:
//   in_i carries requests (mode, from_vertex, to_vertex) on valid/ready; out_o
//   returns results (vertex, status, last). cfg_we_i/cfg_data_i set vertex_count.
//   Edge request: accept, row read, row write; a bad
//   vertex gives one result instead. Clear: valid bits drop at once.
//   Run: whiten the marks, then for each vertex entered read its row and scan
//   it column by column, checking the mark of each successor met. Results
//   then follow one at a time out of the finish list memory, each read
//   before it is loaded into the output register.
//   One request is worked on at a time; ready is high only between requests.
//   A finished result sits in an output register, so the block takes the next
//   request while that result waits; a stalled receiver holds the block only at
//   the point where the next result is due.
//   Reset clears the adjacency valid bits (matrix reads as empty), the vertex
//   count and the control state; no clearing pass is needed.
`timescale 1ns / 1ps

module dfs_topological_sort (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dfs_pkg::CfgW-1:0] cfg_data_i,
  dfs_in_if.sink                   in_i,
  dfs_out_if.source                out_o
);
  import dfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (in_i.mode),
    .from_vertex_i (in_i.from_vertex),
    .to_vertex_i   (in_i.to_vertex),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_vertex_o  (out_o.vertex),
    .out_status_o  (out_o.status),
    .out_last_o    (out_o.last)
  );

  // a new result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  // a vertex is only entered when its mark is white
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.mark_rd == MARK_WHITE)
    else $error("descending into a non-white vertex");

  // one request at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second request accepted back to back");

endmodule

// ----- tb/dfs_tb_pkg.sv -----
// Scoreboard for the depth-first topological sort testbench: predicts the sort results.
// Depends on dfs_pkg for modes, statuses and field widths.
`timescale 1ns / 1ps

package dfs_tb_pkg;
  import dfs_pkg::*;

  typedef struct packed {
    logic [FieldW-1:0] vertex;
    status_e           status;
    logic              last;
  } sort_res_t;

  class sort_scoreboard;
    logic [63:0] graph_rows[64];
    logic [6:0]  vcount;
    sort_res_t   pending[$];
    int          errors;

    function new();
      foreach (graph_rows[r]) graph_rows[r] = '0;
      vcount = '0;
      errors = 0;
    endfunction

    function void set_count(logic [6:0] value);
      vcount = value;
    endfunction

    function void push_res(int v, status_e st, logic lst);
      sort_res_t r;
      r.vertex = v[FieldW-1:0];
      r.status = st;
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // depth first walk; returns 0 when a gray successor is met
    function bit walk_order(int n, ref int order[$]);
      logic [1:0] mark[64];
      int stk_v[64];
      int stk_s[64];
      int depth, v, i;
      order.delete();
      for (int k = 0; k < n; k++) mark[k] = MARK_WHITE;
      for (int root = 0; root < n; root++) begin
        if (mark[root] != MARK_WHITE) continue;
        mark[root] = MARK_GRAY;
        stk_v[0] = root;
        stk_s[0] = 0;
        depth = 1;
        while (depth > 0) begin
          v = stk_v[depth-1];
          i = stk_s[depth-1];
          while (i < n && !graph_rows[v][i]) i++;
          if (i < n) begin
            stk_s[depth-1] = i + 1;
            if (mark[i] == MARK_GRAY) return 0;
            if (mark[i] == MARK_WHITE) begin
              mark[i] = MARK_GRAY;
              stk_v[depth] = i;
              stk_s[depth] = 0;
              depth++;
            end
          end else begin
            mark[v] = MARK_BLACK;
            order.push_back(v);
            depth--;
          end
        end
      end
      return 1;
    endfunction

    // note an accepted request and queue its expected results
    function void note_request(mode_e mode, logic [6:0] a, logic [6:0] b);
      int n, order[$];
      n = (vcount > 64) ? 64 : vcount;
      case (mode)
        MODE_EDGE: begin
          if (a < 1 || b < 1 || a > n || b > n) push_res(0, ST_BAD, 1'b1);
          else graph_rows[a-1][b-1] = 1'b1;
        end
        MODE_CLEAR: foreach (graph_rows[r]) graph_rows[r] = '0;
        MODE_RUN: begin
          if (n == 0) push_res(0, ST_EMPTY, 1'b1);
          else if (!walk_order(n, order)) push_res(0, ST_CYCLE, 1'b1);
          else for (int k = order.size() - 1; k >= 0; k--)
            push_res(order[k] + 1, ST_OK, k == 0);
        end
        default: ;
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [FieldW-1:0] v, logic [StatusW-1:0] st, logic lst);
      sort_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vertex=%0d status=%0d last=%0d", $time, v, st, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.vertex !== v || e.status !== st || e.last !== lst) begin
        $display("%0t: expected vertex=%0d status=%0d last=%0d, got vertex=%0d status=%0d last=%0d",
                 $time, e.vertex, e.status, e.last, v, st, lst);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- tb/tb_dfs_topological_sort.sv -----
// Testbench top for dfs_topological_sort: directed and random edge loads, runs and clears.
// Depends on dfs_pkg, dfs_if, dfs_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dfs_topological_sort;
  import dfs_pkg::*;
  import dfs_tb_pkg::*;

  localparam int MaxCycles = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  int cycle_cnt = 0;
  bit calm = 1'b0;
  sort_scoreboard sb;

  dfs_in_if  req_if();
  dfs_out_if res_if();

  dfs_topological_sort dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_i(req_if.sink), .out_o(res_if.source)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.from_vertex = '0;
    req_if.to_vertex = '0;
    res_if.ready = 1'b0;
    sb = new();
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result sink with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.vertex, res_if.status, res_if.last);
      res_if.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  // send one request, idling at random first
  task automatic send_request(mode_e mode, logic [6:0] a, logic [6:0] b);
    while (!calm && $urandom_range(99) < 9) @(posedge clk_i);
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.from_vertex <= a;
    req_if.to_vertex <= b;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(mode, a, b);
    req_if.valid <= 1'b0;
    // the block never takes a request in the cycle after an accept
    @(posedge clk_i);
  endtask

  // wait for all results, then let an edge write finish before a register write
  task automatic set_vertex_count(int value);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(value[6:0]);
  endtask

  task automatic random_edge(int n, bit dag);
    int a, b;
    a = $urandom_range(n, 1);
    b = $urandom_range(n, 1);
    if (dag && a >= b) begin
      if (a == b) return;
      a = a ^ b; b = a ^ b; a = a ^ b;
    end
    send_request(MODE_EDGE, a[6:0], b[6:0]);
  endtask

  initial begin
    int n, count, edges;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph, bad vertices, unused mode, extremes
    send_request(MODE_RUN, 7'd0, 7'd0);
    send_request(MODE_EDGE, 7'd1, 7'd1);
    set_vertex_count(4);
    send_request(MODE_EDGE, 7'd0, 7'd2);
    send_request(MODE_EDGE, 7'd2, 7'd5);
    send_request(MODE_EDGE, 7'd127, 7'd127);
    send_request(MODE_NONE, 7'd1, 7'd2);
    send_request(MODE_EDGE, 7'd1, 7'd3);
    send_request(MODE_EDGE, 7'd3, 7'd2);
    send_request(MODE_EDGE, 7'd3, 7'd2);
    send_request(MODE_RUN, 7'd127, 7'd0);
    send_request(MODE_EDGE, 7'd2, 7'd1);
    send_request(MODE_RUN, 7'd0, 7'd0);
    send_request(MODE_CLEAR, 7'd85, 7'd42);
    send_request(MODE_EDGE, 7'd4, 7'd4);
    send_request(MODE_RUN, 7'd0, 7'd0);
    send_request(MODE_CLEAR, 7'd0, 7'd0);
    set_vertex_count(64);
    send_request(MODE_EDGE, 7'd64, 7'd1);
    send_request(MODE_EDGE, 7'd65, 7'd1);
    send_request(MODE_RUN, 7'd0, 7'd0);
    set_vertex_count(127);
    send_request(MODE_EDGE, 7'd1, 7'd64);
    send_request(MODE_RUN, 7'd0, 7'd0);
    // shrinking count leaves far edges in place
    set_vertex_count(1);
    send_request(MODE_RUN, 7'd0, 7'd0);
    send_request(MODE_CLEAR, 7'd0, 7'd0);

    // random phases: mostly acyclic graphs, some cyclic and some noise
    count = 0;
    while (count < 380) begin
      calm = (count >= 150 && count < 220);
      case ($urandom_range(9))
        0: n = $urandom_range(64, 40);
        1: n = $urandom_range(127, 65);
        2: n = 0;
        default: n = $urandom_range(12, 1);
      endcase
      set_vertex_count(n);
      send_request(MODE_CLEAR, 7'($urandom), 7'($urandom));
      count++;
      edges = $urandom_range(3 * ((n > 64) ? 64 : (n == 0 ? 1 : n)), 0);
      for (int e = 0; e < edges && count < 380; e++) begin
        if (n == 0 || $urandom_range(19) == 0)
          send_request($urandom_range(3) == 3 ? MODE_NONE : MODE_EDGE,
                       7'($urandom), 7'($urandom));
        else random_edge((n > 64) ? 64 : n, $urandom_range(3) != 0);
        count++;
      end
      send_request(MODE_RUN, 7'($urandom), 7'($urandom));
      count++;
    end
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
